// ===== rtl/hcbd_pkg.sv =====
// Shared types, address map constants and target codes for the bus decoder.
// Used by the decode, memory, top-level and checker files; depends on nothing.
`timescale 1ns / 1ps

package hcbd_pkg;

    localparam int WORK_RAM_BANKS_DEF = 8;
    localparam int BANK_BYTES         = 4096;
    localparam int BANK_OFS_W         = 12;
    localparam int HRAM_BYTES         = 128;
    localparam int HRAM_IDX_W         = 7;

    localparam logic [2:0] TGT_INTERNAL = 3'd0;
    localparam logic [2:0] TGT_ROM      = 3'd1;
    localparam logic [2:0] TGT_VRAM     = 3'd2;
    localparam logic [2:0] TGT_CART_RAM = 3'd3;
    localparam logic [2:0] TGT_OAM      = 3'd4;
    localparam logic [2:0] TGT_IO       = 3'd5;
    localparam logic [2:0] TGT_UNUSABLE = 3'd6;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [15:0] ADDR_ECHO_LO   = 16'hE000;
    localparam logic [15:0] ADDR_ECHO_HI   = 16'hFDFF;
    localparam logic [15:0] ECHO_OFFSET    = 16'h2000;
    localparam logic [15:0] ADDR_ROM_HI    = 16'h7FFF;
    localparam logic [15:0] ADDR_VRAM_HI   = 16'h9FFF;
    localparam logic [15:0] ADDR_CART_HI   = 16'hBFFF;
    localparam logic [15:0] ADDR_WRAM_HI   = 16'hDFFF;
    localparam logic [15:0] ADDR_BANKED_LO = 16'hD000;
    localparam logic [15:0] ADDR_OAM_LO    = 16'hFE00;
    localparam logic [15:0] ADDR_OAM_HI    = 16'hFE9F;
    localparam logic [15:0] ADDR_UNUSE_LO  = 16'hFEA0;
    localparam logic [15:0] ADDR_UNUSE_HI  = 16'hFEFF;
    localparam logic [15:0] ADDR_IO_LO     = 16'hFF00;
    localparam logic [15:0] ADDR_IO_HI     = 16'hFF7F;
    localparam logic [15:0] ADDR_IE        = 16'hFFFF;
    localparam logic [15:0] ADDR_HRAM_LO   = 16'hFF80;
    localparam logic [15:0] BANK_OFS_MASK  = 16'h0FFF;

    localparam logic [7:0] UNUSABLE_BYTE = 8'hFF;

    typedef struct packed {
        logic [2:0]  target;
        logic [15:0] local_address;
        logic        forward_write;
        logic [7:0]  forward_byte;
        logic [7:0]  load_const;
        logic        mem_read;
    } t_dec;

    typedef struct packed {
        logic                  wr;
        logic                  sel_wram;
        logic                  sel_hram;
        logic [HRAM_IDX_W-1:0] hram_idx;
        logic [7:0]            wdata;
    } t_mem_req;

endpackage

// ===== rtl/hcbd_intf.sv =====
// Valid/ready channel interfaces for the request and response words.
// Depends on nothing; used by the top level of the bus decoder.
`timescale 1ns / 1ps

interface hcbd_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [15:0] bus_address;
    logic [7:0]  store_byte;
    logic [2:0]  bank_select;

    modport source (output valid, command, bus_address, store_byte, bank_select,
                    input ready);
    modport sink (input valid, command, bus_address, store_byte, bank_select,
                  output ready);
endinterface

interface hcbd_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  target;
    logic [15:0] local_address;
    logic        forward_write;
    logic [7:0]  forward_byte;
    logic [7:0]  load_byte;

    modport source (output valid, target, local_address, forward_write, forward_byte,
                    load_byte, input ready);
    modport sink (input valid, target, local_address, forward_write, forward_byte,
                  load_byte, output ready);
endinterface

// ===== rtl/hcbd_decode.sv =====
// Combinational address decode: echo folding, region select and work RAM banking.
// Depends on hcbd_pkg.
`timescale 1ns / 1ps

module hcbd_decode #(
    parameter int WORK_RAM_BANKS = hcbd_pkg::WORK_RAM_BANKS_DEF,
    parameter int BANK_W         = (WORK_RAM_BANKS > 1) ? $clog2(WORK_RAM_BANKS) : 1,
    parameter int WRAM_AW        = BANK_W + hcbd_pkg::BANK_OFS_W
) (
    input  logic                  i_colour_mode,
    input  logic                  i_command,
    input  logic [15:0]           i_bus_address,
    input  logic [7:0]            i_store_byte,
    input  logic [2:0]            i_bank_select,
    output hcbd_pkg::t_dec        o_dec,
    output hcbd_pkg::t_mem_req    o_mem,
    output logic [WRAM_AW-1:0]    o_wram_idx
);

    logic [BANK_W-1:0] bank_mod [8];
    logic [BANK_W-1:0] bank;
    logic [15:0]       addr;
    logic              is_wr;

    for (genvar g = 0; g < 8; g++) begin : g_bank_mod
        assign bank_mod[g] = BANK_W'(g % WORK_RAM_BANKS);
    end

    assign is_wr = (i_command == hcbd_pkg::CMD_WRITE);

    always_comb begin
        if (i_bus_address >= hcbd_pkg::ADDR_ECHO_LO
            && i_bus_address <= hcbd_pkg::ADDR_ECHO_HI) begin
            addr = i_bus_address - hcbd_pkg::ECHO_OFFSET;
        end else begin
            addr = i_bus_address;
        end
    end

    always_comb begin
        if (addr < hcbd_pkg::ADDR_BANKED_LO) begin
            bank = '0;
        end else if (i_colour_mode && bank_mod[i_bank_select] != '0) begin
            bank = bank_mod[i_bank_select];
        end else begin
            bank = BANK_W'(1);
        end
    end

    assign o_wram_idx = {bank, addr[hcbd_pkg::BANK_OFS_W-1:0]};

    always_comb begin
        o_dec.target        = hcbd_pkg::TGT_INTERNAL;
        o_dec.local_address = '0;
        o_dec.load_const    = '0;
        o_dec.mem_read      = 1'b0;
        o_dec.forward_write = 1'b0;
        o_dec.forward_byte  = '0;
        o_mem.wr            = is_wr;
        o_mem.sel_wram      = 1'b0;
        o_mem.sel_hram      = 1'b0;
        o_mem.hram_idx      = addr[hcbd_pkg::HRAM_IDX_W-1:0];
        o_mem.wdata         = i_store_byte;
        priority if (addr <= hcbd_pkg::ADDR_ROM_HI) begin
            o_dec.target        = hcbd_pkg::TGT_ROM;
            o_dec.local_address = addr;
        end else if (addr <= hcbd_pkg::ADDR_VRAM_HI) begin
            o_dec.target        = hcbd_pkg::TGT_VRAM;
            o_dec.local_address = {1'b0, addr[14:0]};
        end else if (addr <= hcbd_pkg::ADDR_CART_HI) begin
            o_dec.target        = hcbd_pkg::TGT_CART_RAM;
            o_dec.local_address = addr;
        end else if (addr <= hcbd_pkg::ADDR_WRAM_HI) begin
            o_mem.sel_wram = 1'b1;
            o_dec.mem_read = !is_wr;
        end else if (addr >= hcbd_pkg::ADDR_OAM_LO && addr <= hcbd_pkg::ADDR_OAM_HI) begin
            o_dec.target        = hcbd_pkg::TGT_OAM;
            o_dec.local_address = {8'h00, addr[7:0]};
        end else if (addr >= hcbd_pkg::ADDR_UNUSE_LO && addr <= hcbd_pkg::ADDR_UNUSE_HI) begin
            o_dec.target     = hcbd_pkg::TGT_UNUSABLE;
            o_dec.load_const = hcbd_pkg::UNUSABLE_BYTE;
        end else if ((addr >= hcbd_pkg::ADDR_IO_LO && addr <= hcbd_pkg::ADDR_IO_HI)
                     || addr == hcbd_pkg::ADDR_IE) begin
            o_dec.target        = hcbd_pkg::TGT_IO;
            o_dec.local_address = addr;
        end else begin
            o_mem.sel_hram = 1'b1;
            o_dec.mem_read = !is_wr;
        end
        if (is_wr && o_dec.target != hcbd_pkg::TGT_INTERNAL
                  && o_dec.target != hcbd_pkg::TGT_UNUSABLE) begin
            o_dec.forward_write = 1'b1;
            o_dec.forward_byte  = i_store_byte;
        end
    end

endmodule

// ===== rtl/hcbd_mem.sv =====
// Work RAM and high RAM with registered reads and a clearing sweep after reset.
// Depends on hcbd_pkg.
`timescale 1ns / 1ps

module hcbd_mem #(
    parameter int WORK_RAM_BANKS = hcbd_pkg::WORK_RAM_BANKS_DEF,
    parameter int BANK_W         = (WORK_RAM_BANKS > 1) ? $clog2(WORK_RAM_BANKS) : 1,
    parameter int WRAM_AW        = BANK_W + hcbd_pkg::BANK_OFS_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  hcbd_pkg::t_mem_req    i_req,
    input  logic [WRAM_AW-1:0]    i_wram_idx,
    output logic                  o_busy,
    output logic [7:0]            o_rdata
);

    localparam int WRAM_DEPTH = WORK_RAM_BANKS * hcbd_pkg::BANK_BYTES;

    logic [7:0]         r_wram [WRAM_DEPTH];
    logic [7:0]         r_hram [hcbd_pkg::HRAM_BYTES];
    logic [7:0]         r_wram_q;
    logic [7:0]         r_hram_q;
    logic               r_rd_wram;
    logic               r_clr_active;
    logic [WRAM_AW-1:0] r_clr_addr;
    logic [WRAM_AW-1:0] n_clr_addr;
    logic               n_clr_active;

    always_comb begin
        n_clr_addr   = r_clr_addr;
        n_clr_active = r_clr_active;
        if (r_clr_active) begin
            n_clr_addr = r_clr_addr + 1'b1;
            if (r_clr_addr == WRAM_AW'(WRAM_DEPTH - 1)) begin
                n_clr_active = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else begin
            r_clr_active <= n_clr_active;
            r_clr_addr   <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_active) begin
            r_wram[r_clr_addr] <= '0;
        end else if (i_en && i_req.sel_wram && i_req.wr) begin
            r_wram[i_wram_idx] <= i_req.wdata;
        end
        if (i_en && i_req.sel_wram && !i_req.wr) begin
            r_wram_q <= r_wram[i_wram_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_active) begin
            if (r_clr_addr < WRAM_AW'(hcbd_pkg::HRAM_BYTES)) begin
                r_hram[r_clr_addr[hcbd_pkg::HRAM_IDX_W-1:0]] <= '0;
            end
        end else if (i_en && i_req.sel_hram && i_req.wr) begin
            r_hram[i_req.hram_idx] <= i_req.wdata;
        end
        if (i_en && i_req.sel_hram && !i_req.wr) begin
            r_hram_q <= r_hram[i_req.hram_idx];
        end
        if (i_en) begin
            r_rd_wram <= i_req.sel_wram;
        end
    end

    assign o_busy  = r_clr_active;
    assign o_rdata = r_rd_wram ? r_wram_q : r_hram_q;

endmodule

// ===== rtl/handheld_console_bus_decoder.sv =====
// Top level of the handheld console bus decoder: request/response channels,
// mode register and result register. Depends on hcbd_pkg, hcbd_intf, hcbd_decode, hcbd_mem.
//
// The request channel carries one byte access word per handshake: command,
// bus address, store byte and the current work RAM bank. The response channel
// returns one word per request with the target code, local address, forwarded
// write and read data. Work RAM and high RAM are served inside the block.
// An accepted request is shown as a registered response from the next cycle on.
// Throughput is one word per cycle unless the receiver stalls or the clearing
// sweep runs, set by the single work RAM port read or written once per request.
// The response sits in an output register; while the receiver stalls it holds,
// and a new request is taken in the same cycle that the held word is taken.
// After reset the block clears both RAMs, one work RAM byte per cycle across all
// WORK_RAM_BANKS * 4096 bytes (32768 by default); request ready stays
// low during that sweep. Mode register writes are taken at any time, and the
// mode resets to classic (bank one fixed).
`timescale 1ns / 1ps

module handheld_console_bus_decoder #(
    parameter int WORK_RAM_BANKS = hcbd_pkg::WORK_RAM_BANKS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    hcbd_req_if.sink   i_req,
    hcbd_rsp_if.source o_rsp
);

    localparam int BANK_W  = (WORK_RAM_BANKS > 1) ? $clog2(WORK_RAM_BANKS) : 1;
    localparam int WRAM_AW = BANK_W + hcbd_pkg::BANK_OFS_W;

    logic                r_colour_mode;
    logic                r_out_valid;
    hcbd_pkg::t_dec      r_dec;
    hcbd_pkg::t_dec      dec;
    hcbd_pkg::t_mem_req  mem_req;
    logic [WRAM_AW-1:0]  wram_idx;
    logic                mem_busy;
    logic [7:0]          mem_rdata;
    logic                accept;

    hcbd_decode #(
        .WORK_RAM_BANKS (WORK_RAM_BANKS),
        .BANK_W         (BANK_W),
        .WRAM_AW        (WRAM_AW)
    ) u_decode (
        .i_colour_mode (r_colour_mode),
        .i_command     (i_req.command),
        .i_bus_address (i_req.bus_address),
        .i_store_byte  (i_req.store_byte),
        .i_bank_select (i_req.bank_select),
        .o_dec         (dec),
        .o_mem         (mem_req),
        .o_wram_idx    (wram_idx)
    );

    hcbd_mem #(
        .WORK_RAM_BANKS (WORK_RAM_BANKS),
        .BANK_W         (BANK_W),
        .WRAM_AW        (WRAM_AW)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (accept),
        .i_req      (mem_req),
        .i_wram_idx (wram_idx),
        .o_busy     (mem_busy),
        .o_rdata    (mem_rdata)
    );

    assign i_req.ready = !mem_busy && (!r_out_valid || o_rsp.ready);
    assign accept      = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colour_mode <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_colour_mode <= i_cfg_wr_data;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dec <= dec;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.target        = r_dec.target;
    assign o_rsp.local_address = r_dec.local_address;
    assign o_rsp.forward_write = r_dec.forward_write;
    assign o_rsp.forward_byte  = r_dec.forward_byte;
    assign o_rsp.load_byte     = r_dec.mem_read ? mem_rdata : r_dec.load_const;

endmodule

// ===== rtl/hcbd_checker.sv =====
// Port-level checks on the bus decoder's response words, bound to the top level.
// Depends on hcbd_pkg and handheld_console_bus_decoder.
`timescale 1ns / 1ps

module hcbd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic [2:0]  i_rsp_target,
    input logic [15:0] i_rsp_local_address,
    input logic        i_rsp_forward_write,
    input logic [7:0]  i_rsp_forward_byte,
    input logic [7:0]  i_rsp_load_byte
);

    a_reset_no_rsp: assert property (@(posedge i_clk) !i_rst_n |=> !i_rsp_valid)
        else $error("Response word valid right after reset.");

    a_accept_gives_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> i_rsp_valid)
        else $error("Accepted request word produced no response word.");

    a_unusable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_target == hcbd_pkg::TGT_UNUSABLE)
        |-> (i_rsp_load_byte == hcbd_pkg::UNUSABLE_BYTE && !i_rsp_forward_write
             && i_rsp_local_address == 16'h0000))
        else $error("Unusable range word has wrong fields.");

    a_internal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_target == hcbd_pkg::TGT_INTERNAL)
        |-> (!i_rsp_forward_write && i_rsp_forward_byte == 8'h00
             && i_rsp_local_address == 16'h0000))
        else $error("Internal RAM word forwards a write or an address.");

    a_forward_external: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_forward_write)
        |-> (i_rsp_load_byte == 8'h00 && i_rsp_target != hcbd_pkg::TGT_INTERNAL
             && i_rsp_target != hcbd_pkg::TGT_UNUSABLE))
        else $error("Forwarded write on a target served inside the block.");

endmodule

bind handheld_console_bus_decoder hcbd_checker u_hcbd_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_req_valid         (i_req.valid),
    .i_req_ready         (i_req.ready),
    .i_rsp_valid         (o_rsp.valid),
    .i_rsp_target        (o_rsp.target),
    .i_rsp_local_address (o_rsp.local_address),
    .i_rsp_forward_write (o_rsp.forward_write),
    .i_rsp_forward_byte  (o_rsp.forward_byte),
    .i_rsp_load_byte     (o_rsp.load_byte)
);
